FILE: design/pls_pkg.sv
`default_nettype none

package pls_pkg;

	// Field widths of the request and result channels
	localparam int FUNC_W = 3;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DROP_TAIL = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PREPEND   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DROP_HEAD = 3'd3;
	localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ERASE     = 3'd5;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: design/positional_list_store.sv
// Bounded ordered list with positional insert and erase.
//
// Requests arrive on the in_valid/in_ready channel (func, position, value);
// a transfer takes place when both are high. Each request yields exactly one
// result on the out_valid/out_ready channel (status, removed_value, count).
// The list lives in a registered-read RAM; inserts and erases move entries
// one at a time through a shared address stepper, with a read and a write per moved entry.
//
// Clear, a failed request or an unknown code goes straight to the done state;
// push/insert steps through a read and a write per moved entry, then writes
// the new value; pop/erase reads and captures the removed entry, then steps
// through a read and a write per moved entry.
// Only one request is in flight; in_ready is high while the sequencer is idle.
//
// A finished result sits in the output register. The next request may be
// taken while it waits; if the receiver stalls, that request's result is
// held back until the previous one has been taken, and in_ready stays low.
// Reset clears the entry count and the sequencer; RAM contents are not
// cleared and are never read before being written.
`default_nettype none

module positional_list_store #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [pls_pkg::FUNC_W-1:0]        func,
	input  wire logic [pls_pkg::POS_W-1:0]         position,
	input  wire logic signed [pls_pkg::VAL_W-1:0]  value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [pls_pkg::STAT_W-1:0]             status,
	output logic signed [pls_pkg::VAL_W-1:0]       removed_value,
	output logic [pls_pkg::CNT_W-1:0]              count
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;

	// Sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PUT_RD   = 4'd1;
	localparam logic [3:0] S_PUT_WR   = 4'd2;
	localparam logic [3:0] S_PUT_LAST = 4'd3;
	localparam logic [3:0] S_TAKE_RD  = 4'd4;
	localparam logic [3:0] S_TAKE_CAP = 4'd5;
	localparam logic [3:0] S_SH_RD    = 4'd6;
	localparam logic [3:0] S_SH_WR    = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]                       state_q;
	logic [CW-1:0]                    count_q;
	logic [AW-1:0]                    ptr_q;
	logic [AW-1:0]                    stop_q;
	logic                             up_q;
	logic [pls_pkg::VAL_W-1:0]        val_q;
	logic [pls_pkg::STAT_W-1:0]       status_q;
	logic [pls_pkg::VAL_W-1:0]        removed_q;

	logic                             out_valid_q;
	logic [pls_pkg::STAT_W-1:0]       out_status_q;
	logic [pls_pkg::VAL_W-1:0]        out_removed_q;
	logic [pls_pkg::CNT_W-1:0]        out_count_q;

	logic                             accept;
	logic                             full;
	logic [pls_pkg::POS_W-1:0]        pos_eff;
	logic [CMPW-1:0]                  pos_ext;
	logic [CMPW-1:0]                  cnt_ext;
	logic [AW-1:0]                    pos_idx;
	logic [AW-1:0]                    cnt_idx;
	logic [AW-1:0]                    last_idx;

	logic [AW-1:0]                    step_nxt;
	logic                             step_at_stop;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [DATA_WIDTH-1:0]            ram_wdata;
	logic [AW-1:0]                    ram_raddr;
	logic [DATA_WIDTH-1:0]            ram_rdata;

	assign in_ready      = (state_q == S_IDLE);
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign count         = out_count_q;

	// Request decode helpers
	always_comb begin
		full     = (count_q == CW'(DEPTH));
		pos_eff  = (position == '0) ? pls_pkg::POS_W'(1) : position;
		pos_ext  = CMPW'(pos_eff);
		cnt_ext  = CMPW'(count_q);
		pos_idx  = AW'(pos_eff - pls_pkg::POS_W'(1));
		cnt_idx  = AW'(count_q);
		last_idx = AW'(count_q - CW'(1));
	end

	pls_step_unit #(
		.DEPTH(DEPTH)
	) u_step (
		.ptr     (ptr_q),
		.up      (up_q),
		.stop    (stop_q),
		.nxt     (step_nxt),
		.at_stop (step_at_stop)
	);

	// RAM port control
	always_comb begin
		ram_we    = (state_q == S_PUT_WR) || (state_q == S_PUT_LAST)
			|| (state_q == S_SH_WR);
		ram_waddr = ptr_q;
		ram_wdata = (state_q == S_PUT_LAST) ? DATA_WIDTH'(val_q) : ram_rdata;
		ram_raddr = (state_q == S_TAKE_RD) ? ptr_q : step_nxt;
	end

	pls_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						case (func)
							pls_pkg::FN_APPEND, pls_pkg::FN_PREPEND: begin
								if (!full) begin
									state_q <= (func == pls_pkg::FN_APPEND ||
										count_q == '0) ? S_PUT_LAST : S_PUT_RD;
								end
							end
							pls_pkg::FN_INSERT: begin
								if (!full && !(pos_ext > cnt_ext + CMPW'(1))) begin
									state_q <= (pos_idx == cnt_idx) ? S_PUT_LAST : S_PUT_RD;
								end
							end
							pls_pkg::FN_DROP_TAIL, pls_pkg::FN_DROP_HEAD: begin
								if (count_q != '0) begin
									state_q <= S_TAKE_RD;
								end
							end
							pls_pkg::FN_ERASE: begin
								if (!(pos_ext > cnt_ext)) begin
									state_q <= S_TAKE_RD;
								end
							end
							pls_pkg::FN_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_PUT_RD: begin
					state_q <= S_PUT_WR;
				end
				S_PUT_WR: begin
					state_q <= step_at_stop ? S_PUT_LAST : S_PUT_RD;
				end
				S_PUT_LAST: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_TAKE_RD: begin
					state_q <= S_TAKE_CAP;
				end
				S_TAKE_CAP: begin
					if (ptr_q == stop_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if (step_at_stop) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= $unsigned(value);
			removed_q <= '0;
			status_q  <= pls_pkg::ST_OK;
			ptr_q     <= cnt_idx;
			up_q      <= 1'b0;
			stop_q    <= '0;
			case (func)
				pls_pkg::FN_APPEND: begin
					if (full) status_q <= pls_pkg::ST_FULL;
					stop_q <= cnt_idx;
				end
				pls_pkg::FN_PREPEND: begin
					if (full) status_q <= pls_pkg::ST_FULL;
					stop_q <= '0;
				end
				pls_pkg::FN_INSERT: begin
					if (full) begin
						status_q <= pls_pkg::ST_FULL;
					end else if (pos_ext > cnt_ext + CMPW'(1)) begin
						status_q <= pls_pkg::ST_RANGE;
					end
					stop_q <= pos_idx;
				end
				pls_pkg::FN_DROP_TAIL: begin
					if (count_q == '0) status_q <= pls_pkg::ST_RANGE;
					ptr_q  <= last_idx;
					up_q   <= 1'b1;
					stop_q <= last_idx;
				end
				pls_pkg::FN_DROP_HEAD: begin
					if (count_q == '0) status_q <= pls_pkg::ST_RANGE;
					ptr_q  <= '0;
					up_q   <= 1'b1;
					stop_q <= last_idx;
				end
				pls_pkg::FN_ERASE: begin
					if (pos_ext > cnt_ext) status_q <= pls_pkg::ST_RANGE;
					ptr_q  <= pos_idx;
					up_q   <= 1'b1;
					stop_q <= last_idx;
				end
				default: begin
				end
			endcase
		end else begin
			if (state_q == S_PUT_WR || state_q == S_SH_WR) begin
				ptr_q <= step_nxt;
			end
			if (state_q == S_TAKE_CAP) begin
				removed_q <= pls_pkg::VAL_W'(ram_rdata);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_count_q   <= pls_pkg::CNT_W'(count_q);
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_grows_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("entry count grew by more than one");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("request transfer did not start the sequencer");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
		else $error("RAM written outside an operation");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || out_ready)) |=> out_valid_q)
		else $error("finished request produced no result");

endmodule

`default_nettype wire

FILE: design/pls_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module pls_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/pls_step_unit.sv
`default_nettype none

// Shared address stepper: next slot in the shift direction and end-of-run detect
module pls_step_unit #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic [AW-1:0] ptr,
	input  wire logic          up,
	input  wire logic [AW-1:0] stop,
	output logic      [AW-1:0] nxt,
	output logic               at_stop
);

	always_comb begin
		nxt     = up ? ptr + AW'(1) : ptr - AW'(1);
		at_stop = (nxt == stop);
	end

endmodule

`default_nettype wire

FILE: tb/positional_list_store_tb.sv
module positional_list_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;
	// Settling time after the last result, sized from the longest request plus margin
	localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 800;

	// Code the block leaves undecoded
	localparam logic [pls_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;

	typedef struct {
		logic [pls_pkg::STAT_W-1:0] status;
		logic [pls_pkg::VAL_W-1:0]  removed;
		logic [pls_pkg::CNT_W-1:0]  count;
	} list_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [pls_pkg::FUNC_W-1:0]        func = '0;
	logic [pls_pkg::POS_W-1:0]         position = '0;
	logic signed [pls_pkg::VAL_W-1:0]  value = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [pls_pkg::STAT_W-1:0]        status;
	logic signed [pls_pkg::VAL_W-1:0]  removed_value;
	logic [pls_pkg::CNT_W-1:0]         count;

	// Shadow copy of the list contents, front at index 0
	logic [pls_pkg::VAL_W-1:0] shadow_list[$];
	list_result_t              pending_results[$];
	list_result_t              due;
	int                        fail_count = 0;
	int                        quiet_cycles = 0;
	int                        send_idle_pct = 0;
	int                        recv_stall_pct = 0;
	bit                        grow_phase = 1'b1;

	positional_list_store #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(pls_pkg::VAL_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.removed_value(removed_value),
		.count(count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and queue the result it should give
	function automatic void predict_list_op(input logic [pls_pkg::FUNC_W-1:0] f,
			input logic [pls_pkg::POS_W-1:0] p, input logic [pls_pkg::VAL_W-1:0] v);
		list_result_t r;
		int slot;
		r.status = pls_pkg::ST_OK;
		r.removed = '0;
		slot = (p == 0) ? 0 : int'(p) - 1;
		case (f)
			pls_pkg::FN_APPEND, pls_pkg::FN_PREPEND: begin
				if (shadow_list.size() >= LIST_DEPTH)
					r.status = pls_pkg::ST_FULL;
				else if (f == pls_pkg::FN_APPEND)
					shadow_list.insert(shadow_list.size(), v);
				else
					shadow_list.push_front(v);
			end
			pls_pkg::FN_DROP_TAIL, pls_pkg::FN_DROP_HEAD: begin
				if (shadow_list.size() == 0) begin
					r.status = pls_pkg::ST_RANGE;
				end else if (f == pls_pkg::FN_DROP_TAIL) begin
					r.removed = shadow_list[$];
					shadow_list.delete(shadow_list.size() - 1);
				end else begin
					r.removed = shadow_list.pop_front();
				end
			end
			pls_pkg::FN_INSERT: begin
				// full is checked ahead of the position
				if (shadow_list.size() >= LIST_DEPTH)
					r.status = pls_pkg::ST_FULL;
				else if (slot > shadow_list.size())
					r.status = pls_pkg::ST_RANGE;
				else
					shadow_list.insert(slot, v);
			end
			pls_pkg::FN_ERASE: begin
				if (slot >= shadow_list.size()) begin
					r.status = pls_pkg::ST_RANGE;
				end else begin
					r.removed = shadow_list[slot];
					shadow_list.delete(slot);
				end
			end
			pls_pkg::FN_CLEAR: shadow_list.delete();
			default: ;
		endcase
		r.count = pls_pkg::CNT_W'(shadow_list.size());
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Present one request, hold it until the transfer, then predict
	task automatic send_request(input logic [pls_pkg::FUNC_W-1:0] f,
			input logic [pls_pkg::POS_W-1:0] p, input logic [pls_pkg::VAL_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_list_op(f, p, v);
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Result checker: compare each transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: status %0d removed %0h count %0d",
					status, removed_value, count);
				fail_count++;
			end else begin
				due = pending_results.pop_front();
				if (status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, status);
					fail_count++;
				end
				if (removed_value !== due.removed) begin
					$error("removed_value: expected %0h, got %0h", due.removed,
						removed_value);
					fail_count++;
				end
				if (count !== due.count) begin
					$error("count: expected %0d, got %0d", due.count, count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Empty store: every removal fails, positions past the end are refused
	task automatic test_empty_store();
		send_request(pls_pkg::FN_DROP_TAIL, 5'd0, 32'h0);
		send_request(pls_pkg::FN_DROP_HEAD, 5'd0, 32'h0);
		send_request(pls_pkg::FN_ERASE, 5'd0, 32'h0);
		send_request(pls_pkg::FN_INSERT, 5'd2, 32'h1234_5678);
		send_request(FN_UNUSED, 5'd31, 32'hffff_ffff);
	endtask

	// Small list: each operation, value extremes, edge positions
	task automatic test_positional_ops();
		send_request(pls_pkg::FN_INSERT, 5'd0, 32'h8000_0000);
		send_request(pls_pkg::FN_APPEND, 5'd0, 32'h7fff_ffff);
		send_request(pls_pkg::FN_PREPEND, 5'd0, 32'hffff_ffff);
		send_request(pls_pkg::FN_INSERT, 5'd4, 32'h0);
		send_request(pls_pkg::FN_INSERT, 5'd2, $urandom);
		send_request(pls_pkg::FN_ERASE, 5'd6, 32'h0);
		send_request(pls_pkg::FN_ERASE, 5'd5, 32'h0);
		send_request(pls_pkg::FN_ERASE, 5'd0, 32'h0);
		send_request(pls_pkg::FN_DROP_TAIL, 5'd17, $urandom);
		send_request(pls_pkg::FN_DROP_HEAD, 5'd31, $urandom);
		send_request(FN_UNUSED, 5'd1, $urandom);
		send_request(pls_pkg::FN_CLEAR, 5'd16, $urandom);
		send_request(pls_pkg::FN_INSERT, 5'd1, $urandom);
	endtask

	// Fill to capacity, then push at every end and erase at the limits
	task automatic test_full_store();
		int fill;
		send_request(pls_pkg::FN_CLEAR, 5'd0, 32'h0);
		for (int i = 0; i < LIST_DEPTH; i++) begin
			fill = shadow_list.size();
			case ($urandom_range(0, 2))
				0: send_request(pls_pkg::FN_APPEND, 5'($urandom), $urandom);
				1: send_request(pls_pkg::FN_PREPEND, 5'($urandom), $urandom);
				default: send_request(pls_pkg::FN_INSERT,
					5'($urandom_range(0, fill + 1)), $urandom);
			endcase
		end
		send_request(pls_pkg::FN_APPEND, 5'd0, $urandom);
		send_request(pls_pkg::FN_PREPEND, 5'd0, $urandom);
		send_request(pls_pkg::FN_INSERT, 5'd31, $urandom);
		send_request(pls_pkg::FN_ERASE, 5'd17, 32'h0);
		send_request(pls_pkg::FN_ERASE, 5'd16, 32'h0);
		send_request(pls_pkg::FN_INSERT, 5'd16, 32'h8000_0000);
		send_request(pls_pkg::FN_ERASE, 5'd1, 32'h0);
		send_request(pls_pkg::FN_INSERT, 5'd1, 32'h7fff_ffff);
	endtask

	// Random traffic drifting between filling and draining the list
	task automatic test_random_traffic(input int items);
		logic [pls_pkg::FUNC_W-1:0] f;
		logic [pls_pkg::POS_W-1:0]  p;
		logic [pls_pkg::VAL_W-1:0]  v;
		int fill;
		int roll;
		for (int i = 0; i < items; i++) begin
			fill = shadow_list.size();
			if (fill == LIST_DEPTH)
				grow_phase = 1'b0;
			else if (fill == 0)
				grow_phase = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				grow_phase = !grow_phase;
			roll = $urandom_range(0, 99);
			if (roll < 1) begin
				f = pls_pkg::FN_CLEAR;
			end else if (roll < 3) begin
				f = FN_UNUSED;
			end else if ((roll < 75) == grow_phase) begin
				case ($urandom_range(0, 2))
					0: f = pls_pkg::FN_APPEND;
					1: f = pls_pkg::FN_PREPEND;
					default: f = pls_pkg::FN_INSERT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: f = pls_pkg::FN_DROP_TAIL;
					1: f = pls_pkg::FN_DROP_HEAD;
					default: f = pls_pkg::FN_ERASE;
				endcase
			end
			// mostly legal positions, now and then anything the field holds
			if ($urandom_range(0, 9) == 0)
				p = pls_pkg::POS_W'($urandom);
			else
				p = pls_pkg::POS_W'($urandom_range(0, fill + 1));
			case ($urandom_range(0, 15))
				0: v = 32'h0;
				1: v = 32'h7fff_ffff;
				2: v = 32'h8000_0000;
				3: v = 32'hffff_ffff;
				default: v = $urandom;
			endcase
			send_request(f, p, v);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_stall_pct = 65;
		test_empty_store();
		test_positional_ops();
		test_full_store();
		test_random_traffic(RANDOM_ITEMS / 3);

		send_idle_pct = 65;
		recv_stall_pct = 6;
		test_random_traffic(RANDOM_ITEMS / 3);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
